// ===== src/scv_pkg.sv =====
package scv_pkg;

  localparam int MAX_KERNEL   = 5;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_STEP     = 5;

  localparam int NTAPS   = MAX_KERNEL * MAX_KERNEL;
  localparam int KSZ_W   = 3;
  localparam int DIM_W   = 11;
  localparam int CH_W    = 5;
  localparam int CHP_W   = 4;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int SLOT_W  = 3;
  localparam int TAP_W   = 5;
  localparam int VAL_W   = 16;
  localparam int PIX_W   = 24;
  localparam int PROD_W  = VAL_W + PIX_W;
  localparam int ACC_W   = PROD_W + 6;
  localparam int N_W     = 9;
  localparam int CFG_I_W = 3;

  localparam logic [CFG_I_W-1:0] CFG_KW = 3'd0;
  localparam logic [CFG_I_W-1:0] CFG_KH = 3'd1;
  localparam logic [CFG_I_W-1:0] CFG_ST = 3'd2;
  localparam logic [CFG_I_W-1:0] CFG_IW = 3'd3;
  localparam logic [CFG_I_W-1:0] CFG_IH = 3'd4;
  localparam logic [CFG_I_W-1:0] CFG_CH = 3'd5;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] wcol_t;

  // quotient by a stride of 1 to 5, reciprocal multiply for 3 and 5
  function automatic logic [DIM_W-1:0] div_st(input logic [DIM_W-1:0] x,
                                              input logic [KSZ_W-1:0] st);
    logic [DIM_W+13:0] p;
    logic [DIM_W-1:0] q;
    p = '0;
    case (st)
      3'd2: q = x >> 1;
      3'd3: begin
        p = (DIM_W+14)'(x) * (DIM_W+14)'(14'd5462);
        q = p[DIM_W+13:14];
      end
      3'd4: q = x >> 2;
      3'd5: begin
        p = (DIM_W+14)'(x) * (DIM_W+14)'(14'd3277);
        q = p[DIM_W+13:14];
      end
      default: q = x;
    endcase
    return q;
  endfunction

endpackage

// ===== src/strided_mean_conv2d.sv =====
// path: a window-closing pixel is loaded into the window chain, multiplied over the window,
// divided (no quotient loop when the mean saturates) and issued after any stalled earlier word
// throughput: one sample per cycle while no pixel completes; a completed pixel holds the input
// through the window load, and one with output until its word is issued (single multiplier
// pass over the window columns and a 15-step quotient loop)
// reset: synchronous active-low, registers to defaults, stream position and window to zero
module strided_mean_conv2d import scv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [TAP_W-1:0]     in_weight_slot,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VAL_W-1:0] out_result,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_I_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r;

  logic [KSZ_W-1:0] kw_r, kh_r, st_r;
  logic [DIM_W-1:0] iw_r, ih_r;
  logic [CH_W-1:0]  ch_r;
  logic [N_W-1:0]   n_r;
  logic [DIM_W-1:0] outh_r, outw_r;

  logic signed [VAL_W-1:0] weight_r [NTAPS];
  logic [PIX_W-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
  logic [PIX_W-1:0] rd_r [MAX_KERNEL];

  logic signed [PIX_W-1:0] accum_r, accum_nxt;
  logic [CHP_W-1:0] chp_r;
  logic [COL_W-1:0] col_r, cur_col_r;
  logic [ROW_W-1:0] row_r, cur_row_r;
  logic [SLOT_W-1:0] rslot_r, cur_slot_r;
  logic signed [PIX_W-1:0] pix_r;

  wcol_t new_col;
  wcol_t cell_q [MAX_KERNEL];
  logic  shift;

  logic [KSZ_W-1:0] kx_r, ky_r;
  logic [SLOT_W-1:0] slot_r;
  logic signed [PROD_W-1:0] prod_r;
  logic pv_r;
  logic signed [ACC_W-1:0] acc_r;

  logic neg_r;
  logic [PIX_W-1:0] rem_r;
  logic [PIX_W-2:0] d_r;
  logic [VAL_W-1:0] q_r;
  logic [3:0] cnt_r;

  logic [ROW_W-1:0] ory_r;
  logic [COL_W-1:0] orx_r;
  logic fe_r;

  logic out_valid_r;
  logic signed [VAL_W-1:0] res_r;
  logic [ROW_W-1:0] orow_r;
  logic [COL_W-1:0] ocol_r;
  logic ofe_r;

  logic accept, sample, complete;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign sample   = accept && (in_opcode == OP_SAMPLE);
  assign accum_nxt = accum_r + PIX_W'(in_value);
  assign complete = sample && ((CH_W'(chp_r) + 1'b1) >= ch_r);

  function automatic logic [KSZ_W-1:0] clamp_k(input logic [KSZ_W-1:0] v);
    if (v == '0) return KSZ_W'(1);
    if (v > KSZ_W'(MAX_KERNEL)) return KSZ_W'(MAX_KERNEL);
    return v;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r <= 3'd3;
      kh_r <= 3'd3;
      st_r <= 3'd1;
      iw_r <= DIM_W'(MAX_WIDTH);
      ih_r <= DIM_W'(MAX_HEIGHT);
      ch_r <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KW: kw_r <= clamp_k(cfg_data[KSZ_W-1:0]);
        CFG_KH: kh_r <= clamp_k(cfg_data[KSZ_W-1:0]);
        CFG_ST: begin
          if (cfg_data[KSZ_W-1:0] == '0) st_r <= KSZ_W'(1);
          else if (cfg_data[KSZ_W-1:0] > KSZ_W'(MAX_STEP)) st_r <= KSZ_W'(MAX_STEP);
          else st_r <= cfg_data[KSZ_W-1:0];
        end
        CFG_IW: begin
          if (cfg_data == '0) iw_r <= DIM_W'(1);
          else if (cfg_data > DIM_W'(MAX_WIDTH)) iw_r <= DIM_W'(MAX_WIDTH);
          else iw_r <= cfg_data;
        end
        CFG_IH: begin
          if (cfg_data == '0) ih_r <= DIM_W'(1);
          else if (cfg_data > DIM_W'(MAX_HEIGHT)) ih_r <= DIM_W'(MAX_HEIGHT);
          else ih_r <= cfg_data;
        end
        CFG_CH: begin
          if (cfg_data[CH_W-1:0] == '0) ch_r <= CH_W'(1);
          else if (cfg_data[CH_W-1:0] > CH_W'(MAX_CHANNELS)) ch_r <= CH_W'(MAX_CHANNELS);
          else ch_r <= cfg_data[CH_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // derived figures
  always_ff @(posedge clk) begin
    n_r <= N_W'(kw_r) * N_W'(kh_r) * N_W'(ch_r);
    outh_r <= ((ih_r + 1'b1) >= DIM_W'(kh_r)) ?
              div_st(ih_r + 1'b1 - DIM_W'(kh_r), st_r) : '0;
    outw_r <= ((iw_r + 1'b1) >= DIM_W'(kw_r)) ?
              div_st(iw_r + 1'b1 - DIM_W'(kw_r), st_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_WEIGHT) && (in_weight_slot < TAP_W'(NTAPS))) begin
      weight_r[in_weight_slot] <= in_value;
    end
  end

  // line rows
  always_ff @(posedge clk) begin
    for (int s = 0; s < MAX_KERNEL; s++) begin
      if (complete) begin
        if (rslot_r == SLOT_W'(s)) line_mem[s][col_r] <= accum_nxt;
        rd_r[s] <= line_mem[s][col_r];
      end
    end
  end

  // stream position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      chp_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      rslot_r <= '0;
    end else if (sample) begin
      if (!complete) begin
        accum_r <= accum_nxt;
        chp_r   <= chp_r + 1'b1;
      end else begin
        accum_r <= '0;
        chp_r   <= '0;
        if ((DIM_W'(col_r) + 1'b1) >= iw_r) begin
          col_r <= '0;
          if ((DIM_W'(row_r) + 1'b1) >= ih_r) begin
            row_r   <= '0;
            rslot_r <= '0;
          end else begin
            row_r   <= row_r + 1'b1;
            rslot_r <= (rslot_r == SLOT_W'(MAX_KERNEL - 1)) ? '0 : rslot_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      pix_r      <= accum_nxt;
      cur_col_r  <= col_r;
      cur_row_r  <= row_r;
      cur_slot_r <= rslot_r;
    end
  end

  // window column chain
  always_comb begin
    for (int s = 0; s < MAX_KERNEL; s++) begin
      new_col[s] = (cur_slot_r == SLOT_W'(s)) ? pix_r : rd_r[s];
    end
  end

  assign shift = (state_r == S_LOAD);

  for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_cell
    scv_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (shift),
      .col_in ((i == 0) ? new_col : cell_q[(i == 0) ? 0 : i - 1]),
      .col_out(cell_q[i])
    );
  end

  // window decision
  logic [DIM_W-1:0] oy, ox, qy, qx;
  logic win_ok, emit;
  logic [SLOT_W+1:0] base_v;
  logic [SLOT_W-1:0] base_slot;

  always_comb begin
    win_ok = ((DIM_W'(cur_row_r) + 1'b1) >= DIM_W'(kh_r)) &&
             ((DIM_W'(cur_col_r) + 1'b1) >= DIM_W'(kw_r));
    oy = DIM_W'(cur_row_r) + 1'b1 - DIM_W'(kh_r);
    ox = DIM_W'(cur_col_r) + 1'b1 - DIM_W'(kw_r);
    qy = div_st(oy, st_r);
    qx = div_st(ox, st_r);
    emit = win_ok &&
           ((14'(qy) * 14'(st_r)) == 14'(oy)) &&
           ((14'(qx) * 14'(st_r)) == 14'(ox)) &&
           (qy < outh_r) && (qx < outw_r);
    base_v = (SLOT_W+2)'(cur_slot_r) + (SLOT_W+2)'(MAX_KERNEL + 1) - (SLOT_W+2)'(kh_r);
    base_slot = (base_v >= (SLOT_W+2)'(MAX_KERNEL)) ?
                SLOT_W'(base_v - (SLOT_W+2)'(MAX_KERNEL)) : SLOT_W'(base_v);
  end

  // multiply-accumulate over the window
  logic [KSZ_W-1:0] cidx;
  logic [TAP_W-1:0] widx;
  wcol_t sel_col;
  logic signed [PIX_W-1:0] win_sel;

  assign cidx    = kw_r - 1'b1 - kx_r;
  assign widx    = TAP_W'(ky_r) * TAP_W'(MAX_KERNEL) + TAP_W'(kx_r);
  assign sel_col = cell_q[cidx];
  assign win_sel = sel_col[slot_r];

  always_ff @(posedge clk) begin
    prod_r <= weight_r[widx] * win_sel;
    if (state_r == S_LOAD) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // quotient path
  logic [ACC_W-1:0] mag, tsum;
  logic [33:0] dvd;

  always_comb begin
    mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    tsum = mag + (ACC_W'(n_r) << 11);
    dvd  = tsum[45:12];
  end

  logic div_ge;
  assign div_ge = rem_r >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= (state_r == S_MAC);
      case (state_r)
        S_IDLE: begin
          if (complete) state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= emit ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if ((kx_r + 1'b1) >= kw_r && (ky_r + 1'b1) >= kh_r) state_r <= S_ACC;
        end
        S_ACC: state_r <= S_PREP;
        S_PREP: begin
          state_r <= (dvd >= 34'({n_r, 15'd0})) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        kx_r   <= '0;
        ky_r   <= '0;
        slot_r <= base_slot;
        ory_r  <= ROW_W'(qy);
        orx_r  <= COL_W'(qx);
        fe_r   <= (qy == outh_r - 1'b1) && (qx == outw_r - 1'b1);
      end
      S_MAC: begin
        if ((kx_r + 1'b1) >= kw_r) begin
          kx_r   <= '0;
          ky_r   <= ky_r + 1'b1;
          slot_r <= (slot_r == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_r + 1'b1;
        end else begin
          kx_r <= kx_r + 1'b1;
        end
      end
      S_PREP: begin
        neg_r <= acc_r[ACC_W-1];
        rem_r <= dvd[PIX_W-1:0];
        d_r   <= (PIX_W-1)'(n_r) << 14;
        cnt_r <= 4'd14;
        q_r   <= (dvd >= 34'({n_r, 15'd0})) ? 16'h8000 : '0;
      end
      S_DIV: begin
        if (div_ge) rem_r <= rem_r - {1'b0, d_r};
        q_r   <= {q_r[VAL_W-2:0], div_ge};
        d_r   <= d_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      if (neg_r) res_r <= -$signed(q_r);
      else if (q_r[VAL_W-1]) res_r <= 16'sh7FFF;
      else res_r <= $signed(q_r);
      orow_r <= ory_r;
      ocol_r <= orx_r;
      ofe_r  <= fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = res_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;
  assign out_frame_end = ofe_r;

endmodule

// ===== src/scv_cell.sv =====
module scv_cell import scv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  wcol_t col_in,
  output wcol_t col_out
);

  wcol_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

// ===== src/scv_checker.sv =====
module scv_checker import scv_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_result,
  input logic [ROW_W-1:0]        out_row,
  input logic [COL_W-1:0]        out_col,
  input logic                    out_frame_end
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result) &&
    $stable(out_row) && $stable(out_col) && $stable(out_frame_end))
    else $error("output word changed under stall");

  // a fresh word only follows a busy period
  a_word_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("word appeared without a window pass");

  // idle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("not idle after reset");

  // input side is free as a word issues
  a_free_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("input held after word issue");

endmodule

bind strided_mean_conv2d scv_checker u_scv_checker (.*);

// ===== verif/tb_strided_mean_conv2d.sv =====
module tb_strided_mean_conv2d;
  import scv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1900;
  localparam int SETTLE = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [CFG_I_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic frame_end;
  } window_word_t;

  class conv_scoreboard;
    int unsigned raw_kw, raw_kh, raw_st, raw_iw, raw_ih, raw_ch;
    int weights[NTAPS];
    int lines[MAX_KERNEL][MAX_WIDTH];
    int accum;
    int unsigned chan, col, row;
    window_word_t pending[$];
    int errors;

    function new();
      raw_kw = 3; raw_kh = 3; raw_st = 1;
      raw_iw = 1024; raw_ih = 1024; raw_ch = 1;
      foreach (weights[i]) weights[i] = 0;
      foreach (lines[i, j]) lines[i][j] = 0;
      accum = 0; chan = 0; col = 0; row = 0; errors = 0;
    endfunction

    function int unsigned clip(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
    endfunction

    function int unsigned kw(); return clip(raw_kw, MAX_KERNEL); endfunction
    function int unsigned kh(); return clip(raw_kh, MAX_KERNEL); endfunction
    function int unsigned st(); return clip(raw_st, MAX_STEP); endfunction
    function int unsigned iw(); return clip(raw_iw, MAX_WIDTH); endfunction
    function int unsigned ih(); return clip(raw_ih, MAX_HEIGHT); endfunction
    function int unsigned ch(); return clip(raw_ch, MAX_CHANNELS); endfunction

    function void set_reg(logic [CFG_I_W-1:0] idx, logic [DIM_W-1:0] v);
      case (idx)
        CFG_KW: raw_kw = v[2:0];
        CFG_KH: raw_kh = v[2:0];
        CFG_ST: raw_st = v[2:0];
        CFG_IW: raw_iw = v;
        CFG_IH: raw_ih = v;
        CFG_CH: raw_ch = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic op, logic [TAP_W-1:0] slot, logic signed [VAL_W-1:0] val);
      int unsigned r, c, oh, ow, oy, ox;
      longint total, den, mag, q, res;
      window_word_t w;
      if (op == OP_WEIGHT) begin
        if (slot < NTAPS) weights[slot] = val;
        return;
      end
      accum += val;
      if (chan + 1 < ch()) begin
        chan++;
        return;
      end
      chan = 0;
      r = row;
      c = col;
      lines[r % MAX_KERNEL][c] = accum;
      accum = 0;
      oh = (ih() + 1 >= kh()) ? (ih() + 1 - kh()) / st() : 0;
      ow = (iw() + 1 >= kw()) ? (iw() + 1 - kw()) / st() : 0;
      if (r + 1 >= kh() && c + 1 >= kw()) begin
        oy = r + 1 - kh();
        ox = c + 1 - kw();
        if (oy % st() == 0 && ox % st() == 0 && oy / st() < oh && ox / st() < ow) begin
          total = 0;
          for (int ky = 0; ky < kh(); ky++)
            for (int kx = 0; kx < kw(); kx++)
              total += longint'(weights[ky * MAX_KERNEL + kx]) *
                       longint'(lines[(oy + ky) % MAX_KERNEL][ox + kx]);
          den = longint'(kh() * kw() * ch()) * 4096;
          mag = (total < 0) ? -total : total;
          q = (mag + den / 2) / den;
          if (q > 32768) q = 32768;
          res = (total < 0) ? -q : q;
          if (res > 32767) res = 32767;
          w.result = res[VAL_W-1:0];
          w.row = ROW_W'(oy / st());
          w.col = COL_W'(ox / st());
          w.frame_end = (oy / st() == oh - 1) && (ox / st() == ow - 1);
          pending = {pending, w};
        end
      end
      if (c + 1 >= iw()) begin
        col = 0;
        row = (r + 1 >= ih()) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_word(window_word_t got);
      window_word_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: result %0d row %0d col %0d end %0b", $time,
                 got.result, got.row, got.col, got.frame_end);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t mismatch: expected result %0d row %0d col %0d end %0b, got %0d %0d %0d %0b",
                 $time, want.result, want.row, want.col, want.frame_end,
                 got.result, got.row, got.col, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic in_valid, in_stall, in_opcode;
  logic [TAP_W-1:0] in_weight_slot;
  logic signed [VAL_W-1:0] in_value;
  logic out_valid, out_stall, out_frame_end;
  logic signed [VAL_W-1:0] out_result;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic cfg_we;
  logic [CFG_I_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  conv_scoreboard sb;
  bit jitter;
  int sent;
  int quiet;
  int unsigned iw_pick, ih_pick, ch_pick, frame_words;

  strided_mean_conv2d dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) out_stall <= jitter && ($urandom_range(99) < 8);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_opcode, in_weight_slot, in_value);
      if (out_valid && !out_stall) sb.check_word({out_result, out_row, out_col, out_frame_end});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [TAP_W-1:0] slot, logic [VAL_W-1:0] val);
    while (jitter && $urandom_range(99) < 8) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_weight_slot <= slot;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_I_W-1:0] idx, logic [DIM_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic configure(int kw, int kh, int st, int iw, int ih, int ch);
    cfg_write(CFG_KW, DIM_W'(kw));
    cfg_write(CFG_KH, DIM_W'(kh));
    cfg_write(CFG_ST, DIM_W'(st));
    cfg_write(CFG_IW, DIM_W'(iw));
    cfg_write(CFG_IH, DIM_W'(ih));
    cfg_write(CFG_CH, DIM_W'(ch));
    if ($urandom_range(3) == 0)
      cfg_write(CFG_I_W'(CFG_UNUSED - $urandom_range(1)), DIM_W'($urandom));
    cfg_we <= 0;
  endtask

  task automatic send_pixels(int unsigned n, logic [VAL_W-1:0] fixed, bit use_fixed);
    logic [VAL_W-1:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      if (!use_fixed && $urandom_range(99) < 4)
        send_word(OP_WEIGHT, TAP_W'($urandom_range(0, 31)), VAL_W'($urandom));
      v = use_fixed ? fixed :
          ($urandom_range(2) == 0) ? VAL_W'($urandom_range(0, 8191) - 4096) : VAL_W'($urandom);
      send_word(OP_SAMPLE, TAP_W'($urandom), v);
    end
  endtask

  function automatic int pick_dim();
    case ($urandom_range(19))
      0: return 0;
      1: return $urandom_range(9, 16);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0; in_opcode = 0; in_weight_slot = 0; in_value = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    jitter = 1;
    quiet = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // full-scale weights everywhere, then saturating frames
    for (int i = 0; i < NTAPS; i++)
      send_word(OP_WEIGHT, TAP_W'(i), (i == 24) ? 16'h8000 : 16'h7fff);
    send_word(OP_WEIGHT, 5'd31, 16'h0000);
    drain();
    configure(3, 3, 1, 3, 3, 1);
    send_pixels(9, 16'h7fff, 1);
    send_pixels(9, 16'h8000, 1);
    drain();
    // stride change in the middle of a frame, out-of-range kernel and stride
    configure(2, 2, 1, 6, 6, 2);
    send_pixels(36, 0, 0);
    drain();
    cfg_write(CFG_ST, DIM_W'(2));
    cfg_we <= 0;
    send_pixels(36, 0, 0);
    drain();
    configure(0, 7, 6, 4, 4, 0);
    send_pixels(16, 0, 0);
    drain();
    configure(7, 0, 0, 3, 3, 31);
    send_pixels(9 * 16, 0, 0);
    drain();
    // widest image with no idling, then a tall narrow one
    jitter = 0;
    configure(2, 1, 3, 2047, 1, 1);
    send_pixels(1024, 0, 0);
    drain();
    jitter = 1;
    configure(1, 5, 5, 0, 200, 1);
    send_pixels(200, 0, 0);
    drain();
    // kernel larger than the image
    configure(5, 5, 1, 3, 2, 1);
    send_pixels(6, 0, 0);
    drain();

    for (int phase = 0; sent < RANDOM_WORDS; phase++) begin
      jitter = (phase % 6 != 3);
      iw_pick = pick_dim();
      ih_pick = pick_dim();
      ch_pick = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
      if (sb.clip(iw_pick, MAX_WIDTH) * sb.clip(ih_pick, MAX_HEIGHT) *
          sb.clip(ch_pick, MAX_CHANNELS) > 256) ch_pick = 1;
      configure(($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5),
                ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5),
                ($urandom_range(9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3),
                iw_pick, ih_pick, ch_pick);
      frame_words = sb.iw() * sb.ih() * sb.ch();
      repeat ((frame_words > 64) ? 1 : $urandom_range(1, 2)) send_pixels(frame_words, 0, 0);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
